[rtl/core/pvn_pkg.sv]
// shared constants and types for the probability vector normalizer
package pvn_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int DEF_MAX_TISSUES = 8;
	localparam int PROB_BITS = 16;
	localparam int CFG_W = 4;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int SUM_W = PROB_BITS + $clog2(NUM_SLOTS);
	localparam int Q_W = PROB_BITS + 1;
	localparam int DIV_STEPS = Q_W;
	localparam logic [CFG_W-1:0] NUM_TISSUES_RST = CFG_W'(8);

	typedef struct packed {
		logic              zero;
		logic [SLOT_W-1:0] last;
	} pvn_side_t;

endpackage

[rtl/core/pvn_if.sv]
// item channels of the probability vector normalizer
interface pvn_in_if
	import pvn_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [PROB_BITS-1:0] tissue_0;
	logic [PROB_BITS-1:0] tissue_1;
	logic [PROB_BITS-1:0] tissue_2;
	logic [PROB_BITS-1:0] tissue_3;
	logic [PROB_BITS-1:0] tissue_4;
	logic [PROB_BITS-1:0] tissue_5;
	logic [PROB_BITS-1:0] tissue_6;
	logic [PROB_BITS-1:0] tissue_7;

	modport source (
		output valid, tissue_0, tissue_1, tissue_2, tissue_3,
		       tissue_4, tissue_5, tissue_6, tissue_7,
		input  ready
	);
	modport sink (
		input  valid, tissue_0, tissue_1, tissue_2, tissue_3,
		       tissue_4, tissue_5, tissue_6, tissue_7,
		output ready
	);
endinterface

interface pvn_out_if
	import pvn_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [PROB_BITS-1:0] norm_0;
	logic [PROB_BITS-1:0] norm_1;
	logic [PROB_BITS-1:0] norm_2;
	logic [PROB_BITS-1:0] norm_3;
	logic [PROB_BITS-1:0] norm_4;
	logic [PROB_BITS-1:0] norm_5;
	logic [PROB_BITS-1:0] norm_6;
	logic [PROB_BITS-1:0] norm_7;
	logic                 zero_sum_fallback;

	modport source (
		output valid, norm_0, norm_1, norm_2, norm_3, norm_4, norm_5, norm_6, norm_7,
		       zero_sum_fallback,
		input  ready
	);
	modport sink (
		input  valid, norm_0, norm_1, norm_2, norm_3, norm_4, norm_5, norm_6, norm_7,
		       zero_sum_fallback,
		output ready
	);
endinterface

[rtl/core/pvn_div.sv]
// pipelined restoring divider, one quotient bit per stage, all lanes in step
module pvn_div
	import pvn_pkg::*;
#(
	parameter int MAX_TISSUES = DEF_MAX_TISSUES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PROB_BITS-1:0] in_p [MAX_TISSUES],
	input  logic [SUM_W-1:0]     in_sum,
	input  pvn_side_t            in_side,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [Q_W-1:0]       out_q [MAX_TISSUES],
	output pvn_side_t            out_side
);

	logic [DIV_STEPS-1:0] vld_s;
	logic [DIV_STEPS-1:0] en;
	logic [SUM_W-1:0]     rem_s  [DIV_STEPS][MAX_TISSUES];
	logic [Q_W-1:0]       quo_s  [DIV_STEPS][MAX_TISSUES];
	logic [SUM_W-1:0]     dvs_s  [DIV_STEPS];
	pvn_side_t            side_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		logic [SUM_W-1:0] dvs_prev;
		pvn_side_t        side_prev;
		logic             vld_prev;

		if (j == DIV_STEPS - 1) begin : g_last
			assign en[j] = !vld_s[j] || out_ready;
		end else begin : g_mid
			assign en[j] = !vld_s[j] || en[j+1];
		end

		if (j == 0) begin : g_first
			assign dvs_prev  = in_sum;
			assign side_prev = in_side;
			assign vld_prev  = in_valid;
		end else begin : g_next
			assign dvs_prev  = dvs_s[j-1];
			assign side_prev = side_s[j-1];
			assign vld_prev  = vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en[j]) begin
				vld_s[j] <= vld_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				dvs_s[j]  <= dvs_prev;
				side_s[j] <= side_prev;
			end
		end

		for (genvar k = 0; k < MAX_TISSUES; k++) begin : g_lane
			logic [SUM_W:0]   cur;
			logic [SUM_W:0]   dif;
			logic             ge;
			logic [Q_W-1:0]   quo_prev;

			if (j == 0) begin : g_init
				assign cur      = (SUM_W+1)'(in_p[k]);
				assign quo_prev = '0;
			end else begin : g_shift
				assign cur      = {rem_s[j-1][k], 1'b0};
				assign quo_prev = quo_s[j-1][k];
			end

			assign ge  = cur >= {1'b0, dvs_prev};
			assign dif = cur - {1'b0, dvs_prev};

			always_ff @(posedge clk) begin
				if (en[j]) begin
					rem_s[j][k] <= ge ? dif[SUM_W-1:0] : cur[SUM_W-1:0];
					quo_s[j][k] <= {quo_prev[Q_W-2:0], ge};
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[DIV_STEPS-1];
	assign out_side  = side_s[DIV_STEPS-1];
	for (genvar k = 0; k < MAX_TISSUES; k++) begin : g_out
		assign out_q[k] = quo_s[DIV_STEPS-1][k];
	end

endmodule

[rtl/core/probability_vector_normalize.sv]
// probability vector normalizer top level
//
// channel  dir  handshake     payload
// in_ch    in   valid/ready   tissue_0..tissue_7, 16 bits each
// out_ch   out  valid/ready   norm_0..norm_7, zero_sum_fallback
// cfg      in   cfg_we        cfg_wdata = num_tissues, 4 bits
//
// one item per cycle sustained while out_ch is not stalled; stages: mask, sum, 17 divider
// steps (one quotient bit each, all slots in parallel), output register
// reset clears all valid bits and loads num_tissues with 8
// each stage moves when the next one is empty or moving, so bubbles close up
// and a stall at the output holds every item in place
module probability_vector_normalize
	import pvn_pkg::*;
#(
	parameter int MAX_TISSUES = DEF_MAX_TISSUES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	pvn_in_if.sink           in_ch,
	pvn_out_if.source        out_ch
);

	logic [CFG_W-1:0]     num_tissues_q;
	logic [CFG_W-1:0]     cnt;
	logic [PROB_BITS-1:0] tis [NUM_SLOTS];

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 en1, en2, en3;
	logic [PROB_BITS-1:0] p_s1 [MAX_TISSUES];
	logic [PROB_BITS-1:0] p_s2 [MAX_TISSUES];
	logic [SLOT_W-1:0]    last_s1;
	pvn_side_t            side_s2;
	logic [SUM_W-1:0]     sum_s2;
	logic [SUM_W-1:0]     sum_c;

	logic                 div_in_ready;
	logic                 div_out_valid;
	logic [Q_W-1:0]       div_q [MAX_TISSUES];
	pvn_side_t            div_side;

	logic [PROB_BITS-1:0] norm_c  [NUM_SLOTS];
	logic [PROB_BITS-1:0] norm_s3 [NUM_SLOTS];
	logic                 fb_s3;
	logic [NUM_SLOTS-1:0] nz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tissues_q <= NUM_TISSUES_RST;
		end else if (cfg_we) begin
			num_tissues_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (num_tissues_q == '0) begin
			cnt = CFG_W'(1);
		end else if (num_tissues_q > CFG_W'(MAX_TISSUES)) begin
			cnt = CFG_W'(MAX_TISSUES);
		end else begin
			cnt = num_tissues_q;
		end
	end

	assign tis[0] = in_ch.tissue_0;
	assign tis[1] = in_ch.tissue_1;
	assign tis[2] = in_ch.tissue_2;
	assign tis[3] = in_ch.tissue_3;
	assign tis[4] = in_ch.tissue_4;
	assign tis[5] = in_ch.tissue_5;
	assign tis[6] = in_ch.tissue_6;
	assign tis[7] = in_ch.tissue_7;

	assign en3 = !vld_s3 || out_ch.ready;
	assign en2 = !vld_s2 || div_in_ready;
	assign en1 = !vld_s1 || en2;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_ch.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= div_out_valid;
		end
	end

	// mask slots beyond the in-use count
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < MAX_TISSUES; k++) begin
				p_s1[k] <= (CFG_W'(k) < cnt) ? tis[k] : '0;
			end
			last_s1 <= SLOT_W'(cnt - CFG_W'(1));
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < MAX_TISSUES; k++) begin
			sum_c = sum_c + SUM_W'(p_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2         <= p_s1;
			sum_s2       <= sum_c;
			side_s2.zero <= (sum_c == '0);
			side_s2.last <= last_s1;
		end
	end

	pvn_div #(
		.MAX_TISSUES(MAX_TISSUES)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_in_ready),
		.in_p      (p_s2),
		.in_sum    (sum_s2),
		.in_side   (side_s2),
		.out_valid (div_out_valid),
		.out_ready (en3),
		.out_q     (div_q),
		.out_side  (div_side)
	);

	// saturate, or force the last in-use slot to one on a zero sum
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_norm
		if (k < MAX_TISSUES) begin : g_used
			always_comb begin
				if (div_side.zero) begin
					norm_c[k] = (div_side.last == SLOT_W'(k)) ? '1 : '0;
				end else if (div_q[k][Q_W-1]) begin
					norm_c[k] = '1;
				end else begin
					norm_c[k] = div_q[k][PROB_BITS-1:0];
				end
			end
		end else begin : g_unused
			assign norm_c[k] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			norm_s3 <= norm_c;
			fb_s3   <= div_side.zero;
		end
	end

	assign out_ch.valid             = vld_s3;
	assign out_ch.norm_0            = norm_s3[0];
	assign out_ch.norm_1            = norm_s3[1];
	assign out_ch.norm_2            = norm_s3[2];
	assign out_ch.norm_3            = norm_s3[3];
	assign out_ch.norm_4            = norm_s3[4];
	assign out_ch.norm_5            = norm_s3[5];
	assign out_ch.norm_6            = norm_s3[6];
	assign out_ch.norm_7            = norm_s3[7];
	assign out_ch.zero_sum_fallback = fb_s3;

	always_comb begin
		for (int k = 0; k < NUM_SLOTS; k++) begin
			nz_s3[k] = (norm_s3[k] != '0);
		end
	end

	a_fallback_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && fb_s3 |-> $onehot(nz_s3))
		else $error("fallback item without exactly one nonzero slot");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt != '0 && cnt <= CFG_W'(MAX_TISSUES))
		else $error("in-use count out of range");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s3 |-> in_ch.ready)
		else $error("input stalled while output stage is empty");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !out_ch.ready |=> vld_s3 && $stable(fb_s3) && $stable(nz_s3))
		else $error("output item changed while stalled");

endmodule

[sim/probability_vector_normalize_tb.sv]
// testbench for the probability vector normalizer: directed and random voxels
module probability_vector_normalize_tb;
	import pvn_pkg::*;

	localparam int SETTLE_CYCLES = 25;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int VOXELS_PER_PHASE = 85;

	typedef bit [NUM_SLOTS-1:0][PROB_BITS-1:0] voxel_t;

	typedef struct packed {
		bit     fallback;
		voxel_t norm;
	} norm_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	pvn_in_if in_ch ();
	pvn_out_if out_ch ();

	probability_vector_normalize dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	norm_result_t pending_norms[$];
	bit [CFG_W-1:0] tissue_count = NUM_TISSUES_RST;
	int in_gap_max = 19;
	int out_stall_max = 19;
	int error_count = 0;
	int voxels_sent = 0;
	int results_checked = 0;
	int fallbacks_seen = 0;
	int counts_used = 1;
	int quiet_cycles = 0;

	function automatic norm_result_t normalize_voxel(voxel_t p, bit [CFG_W-1:0] count);
		norm_result_t r;
		int n;
		longint unsigned total;
		longint unsigned q;
		r = '0;
		n = count;
		if (n < 1) n = 1;
		if (n > DEF_MAX_TISSUES) n = DEF_MAX_TISSUES;
		if (n > NUM_SLOTS) n = NUM_SLOTS;
		total = 0;
		for (int k = 0; k < n; k++) total += p[k];
		if (total != 0) begin
			for (int k = 0; k < n; k++) begin
				q = (longint'(p[k]) << PROB_BITS) / total;
				if (q > (1 << PROB_BITS) - 1) q = (1 << PROB_BITS) - 1;
				r.norm[k] = q[PROB_BITS-1:0];
			end
		end else begin
			r.norm[n-1] = '1;
			r.fallback = 1'b1;
		end
		return r;
	endfunction

	function automatic voxel_t random_voxel();
		voxel_t p;
		int kind;
		int slot;
		p = '0;
		kind = $urandom_range(0, 9);
		slot = $urandom_range(0, NUM_SLOTS - 1);
		for (int k = 0; k < NUM_SLOTS; k++) begin
			case (kind)
				0, 1, 2, 3, 4: begin
					p[k] = PROB_BITS'($urandom);
				end
				5, 6: begin
					p[k] = PROB_BITS'($urandom_range(0, 3));
				end
				7: begin
					p[k] = (k == slot) ? PROB_BITS'($urandom) : '0;
				end
				8: begin
					p[k] = '0;
				end
				default: begin
					p[k] = ($urandom_range(0, 1) == 1) ? '1 : '0;
				end
			endcase
		end
		return p;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// expected results are computed as each item is accepted
	always @(posedge clk) begin
		voxel_t p;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			p[0] = in_ch.tissue_0;
			p[1] = in_ch.tissue_1;
			p[2] = in_ch.tissue_2;
			p[3] = in_ch.tissue_3;
			p[4] = in_ch.tissue_4;
			p[5] = in_ch.tissue_5;
			p[6] = in_ch.tissue_6;
			p[7] = in_ch.tissue_7;
			pending_norms.insert(pending_norms.size(), normalize_voxel(p, tissue_count));
			voxels_sent++;
		end
	end

	always @(posedge clk) begin
		norm_result_t want;
		logic [NUM_SLOTS-1:0][PROB_BITS-1:0] got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got[0] = out_ch.norm_0;
			got[1] = out_ch.norm_1;
			got[2] = out_ch.norm_2;
			got[3] = out_ch.norm_3;
			got[4] = out_ch.norm_4;
			got[5] = out_ch.norm_5;
			got[6] = out_ch.norm_6;
			got[7] = out_ch.norm_7;
			if (pending_norms.size() == 0) begin
				$error("result item with no voxel pending");
				error_count++;
			end else begin
				want = pending_norms.pop_front();
				results_checked++;
				if (want.fallback) fallbacks_seen++;
				for (int k = 0; k < NUM_SLOTS; k++) begin
					if (got[k] !== want.norm[k]) begin
						$error("norm_%0d: expected %0d, got %0d", k, want.norm[k], got[k]);
						error_count++;
					end
				end
				if (out_ch.zero_sum_fallback !== want.fallback) begin
					$error("zero_sum_fallback: expected %0d, got %0d",
						want.fallback, out_ch.zero_sum_fallback);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("probability_vector_normalize test failed");
				$finish;
			end
		end
	end

	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = $urandom_range(0, out_stall_max);
			repeat (stall) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic send_voxel(voxel_t p);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.tissue_0 <= p[0];
		in_ch.tissue_1 <= p[1];
		in_ch.tissue_2 <= p[2];
		in_ch.tissue_3 <= p[3];
		in_ch.tissue_4 <= p[4];
		in_ch.tissue_5 <= p[5];
		in_ch.tissue_6 <= p[6];
		in_ch.tissue_7 <= p[7];
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_norms.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tissue_count(bit [CFG_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tissue_count = value;
		counts_used++;
	endtask

	task automatic send_fill(bit [PROB_BITS-1:0] value);
		voxel_t p;
		for (int k = 0; k < NUM_SLOTS; k++) p[k] = value;
		send_voxel(p);
	endtask

	task automatic test_reset_count();
		repeat (4) send_voxel(random_voxel());
		send_fill('0);
	endtask

	task automatic test_field_extremes();
		voxel_t p;
		set_tissue_count(4'd8);
		send_fill('0);
		send_fill('1);
		send_fill(16'd1);
		for (int k = 0; k < NUM_SLOTS; k += 7) begin
			p = '0;
			p[k] = 16'd1;
			send_voxel(p);
			p[k] = '1;
			send_voxel(p);
		end
		for (int k = 0; k < NUM_SLOTS; k++) p[k] = k[0] ? 16'haaaa : 16'h5555;
		send_voxel(p);
		for (int k = 0; k < NUM_SLOTS; k++) p[k] = k[0] ? 16'h5555 : 16'haaaa;
		send_voxel(p);
		for (int k = 0; k < NUM_SLOTS; k++) p[k] = PROB_BITS'(k + 1);
		send_voxel(p);
		p = '0;
		for (int k = 0; k < NUM_SLOTS; k++) p[k] = 16'd1;
		p[3] = '1;
		send_voxel(p);
	endtask

	task automatic test_unused_slots();
		voxel_t p;
		set_tissue_count(4'd3);
		p = '0;
		for (int k = 3; k < NUM_SLOTS; k++) p[k] = '1;
		send_voxel(p);
		p[0] = 16'd100;
		p[2] = 16'd300;
		send_voxel(p);
		set_tissue_count(4'd1);
		send_voxel(p);
		p[0] = '0;
		send_voxel(p);
	endtask

	task automatic test_count_settings();
		for (int c = 0; c < (1 << CFG_W); c++) begin
			set_tissue_count(CFG_W'(c));
			send_fill('0);
			send_fill('1);
			repeat (4) send_voxel(random_voxel());
		end
	endtask

	task automatic test_random_voxels();
		bit [CFG_W-1:0] counts [RANDOM_PHASES] = '{4'd8, 4'd1, 4'd0, 4'd15,
			4'd2, 4'd7, 4'd5, 4'd9};
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_tissue_count(counts[ph]);
			in_gap_max = (ph % 3 == 0) ? 0 : 19;
			out_stall_max = (ph % 4 == 1) ? 0 : 19;
			repeat (VOXELS_PER_PHASE) send_voxel(random_voxel());
		end
		in_gap_max = 19;
		out_stall_max = 19;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.tissue_0 = '0;
		in_ch.tissue_1 = '0;
		in_ch.tissue_2 = '0;
		in_ch.tissue_3 = '0;
		in_ch.tissue_4 = '0;
		in_ch.tissue_5 = '0;
		in_ch.tissue_6 = '0;
		in_ch.tissue_7 = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_field_extremes();
		test_unused_slots();
		test_count_settings();
		test_random_voxels();
		drain();

		$display("checked %0d of %0d voxels over %0d tissue-count writes incl. reset",
			results_checked, voxels_sent, counts_used);
		$display("%0d voxels took the zero-sum fallback path", fallbacks_seen);
		if (error_count == 0) begin
			$display("probability_vector_normalize test passed");
		end else begin
			$display("probability_vector_normalize test failed");
		end
		$finish;
	end

endmodule

[probability_vector_normalize.f]
rtl/core/pvn_pkg.sv
rtl/core/pvn_if.sv
rtl/core/pvn_div.sv
rtl/core/probability_vector_normalize.sv
sim/probability_vector_normalize_tb.sv
